### hdl/camera_block_parser_with_averaging_core_macros.svh
// Assertion helpers used by the block's core RTL file.
`ifndef CAMERA_BLOCK_PARSER_WITH_AVERAGING_CORE_MACROS_SVH
`define CAMERA_BLOCK_PARSER_WITH_AVERAGING_CORE_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define CPBA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cpba check failed: same-cycle implication");

// Check that cons holds in the cycle after ante.
`define CPBA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cpba check failed: next-cycle implication");

`endif

### hdl/cpba_pkg.sv
package cpba_pkg;

	localparam int WINDOW_DEPTH = 16;
	localparam int WIN_IDX_W    = $clog2(WINDOW_DEPTH);
	localparam int SUM_W        = 16 + WIN_IDX_W;

	localparam logic [15:0] SYNC_WORD = 16'hAA55;

	// one window sample: x, y and width of a block
	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] width;
	} sample_t;

	// window write request
	typedef struct packed {
		logic    push;
		sample_t sample;
	} win_push_t;

	// one result beat
	typedef struct packed {
		logic        found;
		logic [15:0] signature;
		logic [15:0] x_average;
		logic [15:0] y_average;
		logic [15:0] width_average;
		logic [15:0] height_raw;
	} result_t;

endpackage

### hdl/camera_block_parser_with_averaging_core.sv
// channel | handshake            | payload
// --------+----------------------+-----------------------------------------------
// input   | in_valid / in_stall  | word
// output  | out_valid / out_stall| found, signature, x_average, y_average,
//         |                      | width_average, height_raw
//
// One word is taken every cycle unless in_stall is high; results are registered.
// The oldest window sample is read from the ring memory ahead of the height word.
// Reset clears the parser, the running sums and the per-entry valid bits at once.
// A two-beat output stage absorbs stalls; input stalls only while both beats are full.
`include "camera_block_parser_with_averaging_core_macros.svh"

module camera_block_parser_with_averaging_core
	import cpba_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        found,
	output logic [15:0] signature,
	output logic [15:0] x_average,
	output logic [15:0] y_average,
	output logic [15:0] width_average,
	output logic [15:0] height_raw
);

	typedef enum logic [7:0] {
		PH_IDLE       = 8'b0000_0001,
		PH_AFTER_SYNC = 8'b0000_0010,
		PH_CHECKSUM   = 8'b0000_0100,
		PH_SIG        = 8'b0000_1000,
		PH_X          = 8'b0001_0000,
		PH_Y          = 8'b0010_0000,
		PH_WIDTH      = 8'b0100_0000,
		PH_HEIGHT     = 8'b1000_0000
	} phase_t;

	phase_t         phase_q;
	phase_t         phase_d;
	logic [15:0]    sig_q;
	sample_t        held_q;
	logic [SUM_W-1:0] sum_x_q;
	logic [SUM_W-1:0] sum_y_q;
	logic [SUM_W-1:0] sum_w_q;
	logic [SUM_W-1:0] sum_x_d;
	logic [SUM_W-1:0] sum_y_d;
	logic [SUM_W-1:0] sum_w_d;
	logic           in_acc;
	logic           is_sync;
	logic           res_push;
	logic           fifo_full;
	result_t        res;
	result_t        out_res;
	win_push_t      win_push;
	sample_t        oldest;

	assign in_acc   = in_valid && !in_stall;
	assign in_stall = fifo_full;
	assign is_sync  = (word == SYNC_WORD);

	// next parse phase
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_IDLE:       phase_d = is_sync ? PH_AFTER_SYNC : PH_IDLE;
			PH_AFTER_SYNC: phase_d = is_sync ? PH_CHECKSUM : PH_SIG;
			PH_CHECKSUM:   phase_d = PH_SIG;
			PH_SIG:        phase_d = PH_X;
			PH_X:          phase_d = PH_Y;
			PH_Y:          phase_d = PH_WIDTH;
			PH_WIDTH:      phase_d = PH_HEIGHT;
			PH_HEIGHT:     phase_d = PH_IDLE;
			default:       phase_d = PH_IDLE;
		endcase
	end

	// advance the parser on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else if (in_acc) begin
			phase_q <= phase_d;
		end
	end

	// capture block fields
	always_ff @(posedge clk) begin
		if (in_acc) begin
			case (phase_q)
				PH_SIG:   sig_q        <= word;
				PH_X:     held_q.x     <= word;
				PH_Y:     held_q.y     <= word;
				PH_WIDTH: held_q.width <= word;
				default:  ;
			endcase
		end
	end

	// push the held sample into the windows on height
	assign win_push.push   = in_acc && (phase_q == PH_HEIGHT);
	assign win_push.sample = held_q;

	cpba_window_mem u_win (
		.clk      (clk),
		.arst_n   (arst_n),
		.win_push (win_push),
		.oldest   (oldest)
	);

	// drop the oldest tap, add the new one
	assign sum_x_d = sum_x_q - {{WIN_IDX_W{1'b0}}, oldest.x} + {{WIN_IDX_W{1'b0}}, held_q.x};
	assign sum_y_d = sum_y_q - {{WIN_IDX_W{1'b0}}, oldest.y} + {{WIN_IDX_W{1'b0}}, held_q.y};
	assign sum_w_d = sum_w_q - {{WIN_IDX_W{1'b0}}, oldest.width}
		+ {{WIN_IDX_W{1'b0}}, held_q.width};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_x_q <= '0;
			sum_y_q <= '0;
			sum_w_q <= '0;
		end else if (win_push.push) begin
			sum_x_q <= sum_x_d;
			sum_y_q <= sum_y_d;
			sum_w_q <= sum_w_d;
		end
	end

	// form the result: block averages on height, all zeros for a stray idle word
	assign res_push = in_acc && (((phase_q == PH_IDLE) && !is_sync) || (phase_q == PH_HEIGHT));

	always_comb begin
		res = '0;
		if (phase_q == PH_HEIGHT) begin
			res.found         = 1'b1;
			res.signature     = sig_q;
			res.x_average     = sum_x_d[WIN_IDX_W +: 16];
			res.y_average     = sum_y_d[WIN_IDX_W +: 16];
			res.width_average = sum_w_d[WIN_IDX_W +: 16];
			res.height_raw    = word;
		end
	end

	cpba_out_skid u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.data      (res),
		.full      (fifo_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_res)
	);

	assign found         = out_res.found;
	assign signature     = out_res.signature;
	assign x_average     = out_res.x_average;
	assign y_average     = out_res.y_average;
	assign width_average = out_res.width_average;
	assign height_raw    = out_res.height_raw;

	`CPBA_ASSERT_NXT(a_push_returns_idle, clk, arst_n, win_push.push, phase_q == PH_IDLE)
	`CPBA_ASSERT_IMP(a_stall_has_backlog, clk, arst_n, in_stall, out_valid)
	`CPBA_ASSERT_NXT(a_phase_holds_idle, clk, arst_n, !in_acc, $stable(phase_q))

endmodule

### hdl/cpba_window_mem.sv
module cpba_window_mem
	import cpba_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  win_push_t win_push,
	output sample_t   oldest
);

	sample_t                 mem [WINDOW_DEPTH];
	sample_t                 rd_q;
	logic                    rd_valid_q;
	logic [WINDOW_DEPTH-1:0] valid_q;
	logic [WIN_IDX_W-1:0]    ptr_q;

	// write the new sample over the oldest one, read the oldest entry every cycle
	always_ff @(posedge clk) begin
		if (win_push.push) begin
			mem[ptr_q] <= win_push.sample;
		end
		rd_q <= mem[ptr_q];
	end

	// advance the ring pointer and mark written entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q      <= '0;
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			rd_valid_q <= valid_q[ptr_q];
			if (win_push.push) begin
				valid_q[ptr_q] <= 1'b1;
				ptr_q          <= ptr_q + 1'b1;
			end
		end
	end

	// an entry never written reads as a cleared tap
	assign oldest = rd_valid_q ? rd_q : '0;

endmodule

### hdl/cpba_out_skid.sv
module cpba_out_skid
	import cpba_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t data,
	output logic    full,
	output logic    out_valid,
	input  logic    out_stall,
	output result_t out_data
);

	result_t out_q;
	result_t skid_q;
	logic    out_valid_q;
	logic    skid_valid_q;
	logic    pop;

	assign pop = out_valid_q && !out_stall;

	// hold payloads; load the output register first, the skid stage when it is stalled
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (!out_valid_q || pop) begin
				out_q <= data;
			end else begin
				skid_q <= data;
			end
		end
	end

	// track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (!out_valid_q || pop) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

### tb/sv/camera_block_parser_with_averaging_core_test.sv
module camera_block_parser_with_averaging_core_test;
	import cpba_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int RANDOM_WORDS  = 800;
	localparam int HOLD_TRIGGER  = 150;
	localparam int HOLD_CYCLES   = 300;
	localparam int DRAIN_AT_WORD = 400;
	localparam int SETTLE_CYCLES = 16;

	typedef enum logic [2:0] {
		SEEK_SYNC,
		GOT_SYNC,
		GET_CHECKSUM,
		GET_SIGNATURE,
		GET_X,
		GET_Y,
		GET_WIDTH,
		GET_HEIGHT
	} parse_phase_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [15:0] word = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        found;
	logic [15:0] signature;
	logic [15:0] x_average;
	logic [15:0] y_average;
	logic [15:0] width_average;
	logic [15:0] height_raw;

	// words waiting to be sent, with the idle cycles before each and a drain mark
	logic [15:0] pending_words [$];
	int          pending_gaps [$];
	bit          drain_before [$];
	result_t     expected_results [$];

	// predictor state
	parse_phase_t   phase;
	logic [15:0]    signature_hold;
	logic [15:0]    sample_hold [3];
	logic [15:0]    taps [3][WINDOW_DEPTH];
	logic [SUM_W-1:0] tap_sums [3];

	int mismatch_count = 0;
	int cycle_count = 0;
	int words_accepted = 0;
	int gap_count = 0;
	int stall_left = 0;
	int next_stall;
	int tx_calm_left = 0;
	int rx_calm_left = 0;
	int results_seen = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	bit long_hold = 1'b0;

	camera_block_parser_with_averaging_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.word         (word),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.found        (found),
		.signature    (signature),
		.x_average    (x_average),
		.y_average    (y_average),
		.width_average(width_average),
		.height_raw   (height_raw)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// advance the parser by one word and queue the result it yields
	task automatic track_block_word(input logic [15:0] w);
		result_t res;
		res = '0;
		case (phase)
			SEEK_SYNC: begin
				if (w == SYNC_WORD)
					phase = GOT_SYNC;
				else
					expected_results.push_back(res);
			end
			GOT_SYNC:      phase = (w == SYNC_WORD) ? GET_CHECKSUM : GET_SIGNATURE;
			GET_CHECKSUM:  phase = GET_SIGNATURE;
			GET_SIGNATURE: begin
				signature_hold = w;
				phase = GET_X;
			end
			GET_X: begin
				sample_hold[0] = w;
				phase = GET_Y;
			end
			GET_Y: begin
				sample_hold[1] = w;
				phase = GET_WIDTH;
			end
			GET_WIDTH: begin
				sample_hold[2] = w;
				phase = GET_HEIGHT;
			end
			default: begin
				// push x, y and width into their windows, drop the oldest
				for (int k = 0; k < 3; k++) begin
					tap_sums[k] = tap_sums[k] - taps[k][0] + sample_hold[k];
					for (int i = 0; i < WINDOW_DEPTH - 1; i++)
						taps[k][i] = taps[k][i + 1];
					taps[k][WINDOW_DEPTH - 1] = sample_hold[k];
				end
				res.found         = 1'b1;
				res.signature     = signature_hold;
				res.x_average     = 16'(tap_sums[0] / WINDOW_DEPTH);
				res.y_average     = 16'(tap_sums[1] / WINDOW_DEPTH);
				res.width_average = 16'(tap_sums[2] / WINDOW_DEPTH);
				res.height_raw    = w;
				expected_results.push_back(res);
				phase = SEEK_SYNC;
			end
		endcase
	endtask

	function automatic void check_field(input string field_name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, field_name, want, got);
			mismatch_count++;
		end
	endfunction

	// queue one word with its idle gap; calm stretches send back to back
	task automatic queue_word(input logic [15:0] w);
		int gap;
		if (tx_calm_left > 0) begin
			tx_calm_left--;
			gap = 0;
		end else begin
			if ($urandom_range(0, 15) == 0)
				tx_calm_left = 30;
			gap = $urandom_range(0, 7);
		end
		drain_before.push_back(pending_words.size() == DRAIN_AT_WORD);
		pending_words.push_back(w);
		pending_gaps.push_back(gap);
	endtask

	// field content that favors the edges
	function automatic logic [15:0] pick_value();
		case ($urandom_range(0, 7))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			2:       return SYNC_WORD;
			default: return 16'($urandom);
		endcase
	endfunction

	// driver: offer the next word once the slot is free, its gap has passed and any drain is done
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			word <= '0;
			gap_count <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				track_block_word(word);
				words_accepted <= words_accepted + 1;
			end
			if (!in_valid || !in_stall) begin
				if (pending_words.size() == 0) begin
					in_valid <= 1'b0;
				end else if (drain_before[0] && expected_results.size() != 0) begin
					in_valid <= 1'b0;
				end else if (gap_count < pending_gaps[0]) begin
					gap_count <= gap_count + 1;
					in_valid <= 1'b0;
				end else begin
					word <= pending_words.pop_front();
					void'(pending_gaps.pop_front());
					void'(drain_before.pop_front());
					gap_count <= 0;
					in_valid <= 1'b1;
				end
			end
		end
	end

	// hold the output off for a long stretch once traffic is flowing
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_hold <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && words_accepted >= HOLD_TRIGGER) begin
			long_hold <= 1'b1;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			long_hold <= (hold_left > 1);
		end
	end

	// monitor: check each result beat against the oldest expectation and draw random stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, got found %b sig %h",
						$time, found, signature);
					mismatch_count++;
				end else begin
					result_t want;
					want = expected_results.pop_front();
					check_field("found", 16'(want.found), 16'(found));
					check_field("signature", want.signature, signature);
					check_field("x_average", want.x_average, x_average);
					check_field("y_average", want.y_average, y_average);
					check_field("width_average", want.width_average, width_average);
					check_field("height_raw", want.height_raw, height_raw);
				end
				results_seen++;
				if (results_seen % 64 == 0)
					rx_calm_left = ($urandom_range(0, 2) == 0) ? 40 : 0;
				if (rx_calm_left > 0) begin
					rx_calm_left--;
					next_stall = 0;
				end else begin
					next_stall = $urandom_range(0, 7);
				end
			end else begin
				next_stall = (stall_left > 0) ? stall_left - 1 : 0;
			end
			stall_left <= next_stall;
			out_stall <= (next_stall != 0) || long_hold;
		end
	end

	// bound the run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("camera_block_parser_with_averaging_core test failed");
			$finish;
		end
	end

	initial begin
		int target;
		int n;
		phase = SEEK_SYNC;
		signature_hold = '0;
		for (int k = 0; k < 3; k++) begin
			sample_hold[k] = '0;
			tap_sums[k] = '0;
			for (int i = 0; i < WINDOW_DEPTH; i++)
				taps[k][i] = '0;
		end

		// directed: idle noise at the edges, a double-sync block, a single-sync block
		queue_word(16'h0000);
		queue_word(16'hFFFF);
		queue_word(16'hAA54);
		queue_word(SYNC_WORD);
		queue_word(SYNC_WORD);
		queue_word(SYNC_WORD);
		queue_word(16'hFFFF);
		queue_word(16'hFFFF);
		queue_word(16'h0000);
		queue_word(SYNC_WORD);
		queue_word(16'hFFFF);
		queue_word(SYNC_WORD);
		queue_word(16'h1234);
		queue_word(16'h0000);
		queue_word(16'h0000);
		queue_word(16'hFFFF);
		queue_word(16'hFFFF);
		queue_word(16'h0000);
		queue_word(16'h5555);

		// random: mostly well-formed blocks, some noise and cut-short blocks
		target = pending_words.size() + RANDOM_WORDS;
		while (pending_words.size() < target) begin
			case ($urandom_range(0, 9))
				7, 8: begin
					n = $urandom_range(1, 4);
					repeat (n) queue_word(16'($urandom));
				end
				9: begin
					queue_word(SYNC_WORD);
					n = $urandom_range(1, 4);
					repeat (n) queue_word(pick_value());
				end
				default: begin
					queue_word(SYNC_WORD);
					if ($urandom_range(0, 1)) begin
						queue_word(SYNC_WORD);
						queue_word(pick_value());
					end else begin
						queue_word(16'($urandom));
					end
					repeat (5) queue_word(pick_value());
				end
			endcase
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_words.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (expected_results.size() != 0) begin
			$display("%0t: %0d results never arrived, expected none left, got %0d",
				$time, expected_results.size(), expected_results.size());
			mismatch_count++;
		end
		if (mismatch_count == 0)
			$display("camera_block_parser_with_averaging_core test passed");
		else
			$display("camera_block_parser_with_averaging_core test failed");
		$finish;
	end

endmodule
